@@ hw/rtl/fdsd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdsd_pkg
// Shared types and constants of the four-digit seven-segment serial driver.
// ----------------------------------------------------------------------------
package fdsd_pkg;

    localparam int PHASE_W = 8;

    // Command bytes of the three frames.
    localparam logic [7:0] CMD_DATA = 8'h40;
    localparam logic [7:0] CMD_ADDR = 8'hC0;
    localparam logic [7:0] CMD_CTRL = 8'h88;

    // A short frame is start, one byte with its ack, and stop.
    localparam int START_LEN   = 3;
    localparam int STOP_LEN    = 3;
    localparam int BYTE_SLOT   = 18;
    localparam int SHORT_FRAME = START_LEN + BYTE_SLOT + STOP_LEN;

    // x / 18 == (x * 57) >> 10 for every 8-bit x.
    localparam int DIV18_MUL   = 57;
    localparam int DIV18_SHIFT = 10;

    // x / 10 == (x * 52429) >> 19 for every 16-bit x.
    localparam logic [15:0] DIV10_MUL = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    typedef struct packed {
        logic clk;
        logic dio;
    } fdsd_pins_t;

    typedef struct packed {
        logic busy;
        logic dio;
        logic clk;
    } fdsd_result_t;

    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        unique case (digit)
            4'h0: code = 8'h3f;
            4'h1: code = 8'h06;
            4'h2: code = 8'h5b;
            4'h3: code = 8'h4f;
            4'h4: code = 8'h66;
            4'h5: code = 8'h6d;
            4'h6: code = 8'h7d;
            4'h7: code = 8'h07;
            4'h8: code = 8'h7f;
            4'h9: code = 8'h6f;
            4'ha: code = 8'h77;
            4'hb: code = 8'h7c;
            4'hc: code = 8'h39;
            4'hd: code = 8'h5e;
            4'he: code = 8'h79;
            4'hf: code = 8'h71;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/fdsd_digit_split.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdsd_digit_split
// Splits a loaded number into decimal digits, one digit per clock cycle.
// ----------------------------------------------------------------------------
module fdsd_digit_split
    import fdsd_pkg::*;
#(
    parameter int DIGITS = 4
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start_i,
    input  wire logic [15:0]             value_i,
    output logic      [DIGITS-1:0][3:0]  digits_o
);

    localparam int CNT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    logic [15:0]            val_reg;
    logic [15:0]            val_next;
    logic [CNT_W-1:0]       idx_reg;
    logic [CNT_W-1:0]       idx_next;
    logic                   active_reg;
    logic                   active_next;
    logic [DIGITS-1:0][3:0] digits_reg;
    logic [DIGITS-1:0][3:0] digits_next;
    logic [31:0]            prod;
    logic [15:0]            quot;
    logic [3:0]             rem;

    assign prod = 32'(val_reg) * 32'(DIV10_MUL);
    assign quot = 16'(prod >> DIV10_SHIFT);
    assign rem  = 4'(val_reg - 16'(quot * 16'd10));

    always_comb begin
        val_next    = val_reg;
        idx_next    = idx_reg;
        active_next = active_reg;
        digits_next = digits_reg;
        if (start_i) begin
            val_next    = value_i;
            idx_next    = '0;
            active_next = 1'b1;
        end else if (active_reg) begin
            for (int i = 0; i < DIGITS; i++) begin
                if (idx_reg == CNT_W'(i)) begin
                    digits_next[i] = rem;
                end
            end
            val_next = quot;
            idx_next = CNT_W'(idx_reg + 1'b1);
            if (idx_reg == CNT_W'(DIGITS - 1)) begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= '0;
            active_reg <= 1'b0;
            digits_reg <= '0;
        end else begin
            idx_reg    <= idx_next;
            active_reg <= active_next;
            digits_reg <= digits_next;
        end
        val_reg <= val_next;
    end

    assign digits_o = digits_reg;

endmodule
`default_nettype wire

@@ hw/rtl/fdsd_phase_gen.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdsd_phase_gen
// Maps a waveform phase number to the clock and data pin levels.
// ----------------------------------------------------------------------------
module fdsd_phase_gen
    import fdsd_pkg::*;
#(
    parameter int DIGITS = 4
) (
    input  wire logic [PHASE_W-1:0]     phase_i,
    input  wire logic [DIGITS-1:0][3:0] digits_i,
    input  wire logic [2:0]             brightness_i,
    output fdsd_pins_t                  pins_o
);

    localparam int MID_FRAME = 2 * START_LEN + BYTE_SLOT * (1 + DIGITS);

    localparam logic [1:0] FRAME_DATA = 2'd0;
    localparam logic [1:0] FRAME_DISP = 2'd1;
    localparam logic [1:0] FRAME_CTRL = 2'd2;

    logic [PHASE_W-1:0] p;
    logic [PHASE_W-1:0] q;
    logic [PHASE_W-1:0] q3;
    logic [PHASE_W-1:0] len;
    logic [PHASE_W-1:0] stop_pos;
    logic [PHASE_W-1:0] k;
    logic [PHASE_W-1:0] r;
    logic [13:0]        prod;
    logic [1:0]         frame;
    logic [3:0]         digit;
    logic [7:0]         byte_val;

    always_comb begin
        p = PHASE_W'(phase_i - 1'b1);
        priority if (p < PHASE_W'(SHORT_FRAME)) begin
            frame = FRAME_DATA;
            q     = p;
            len   = PHASE_W'(SHORT_FRAME);
        end else if (p < PHASE_W'(SHORT_FRAME + MID_FRAME)) begin
            frame = FRAME_DISP;
            q     = PHASE_W'(p - PHASE_W'(SHORT_FRAME));
            len   = PHASE_W'(MID_FRAME);
        end else begin
            frame = FRAME_CTRL;
            q     = PHASE_W'(p - PHASE_W'(SHORT_FRAME + MID_FRAME));
            len   = PHASE_W'(SHORT_FRAME);
        end

        stop_pos = PHASE_W'(len - PHASE_W'(STOP_LEN));
        q3       = PHASE_W'(q - PHASE_W'(START_LEN));
        prod     = 14'(q3) * 14'(DIV18_MUL);
        k        = PHASE_W'(prod >> DIV18_SHIFT);
        r        = PHASE_W'(q3 - PHASE_W'(k * PHASE_W'(BYTE_SLOT)));

        // Digit bytes go out most significant digit first.
        digit = '0;
        for (int i = 0; i < DIGITS; i++) begin
            if (k == PHASE_W'(DIGITS - i)) begin
                digit = digits_i[i];
            end
        end

        unique case (frame)
            FRAME_DATA: byte_val = CMD_DATA;
            FRAME_DISP: byte_val = (k == '0) ? CMD_ADDR : seg_code(digit);
            default:    byte_val = CMD_CTRL + 8'(brightness_i);
        endcase

        priority if (q < PHASE_W'(START_LEN)) begin
            pins_o.clk = (q != PHASE_W'(2));
            pins_o.dio = (q == '0);
        end else if (q >= stop_pos) begin
            pins_o.clk = (q != stop_pos);
            pins_o.dio = (q == PHASE_W'(stop_pos + PHASE_W'(2)));
        end else if (r < PHASE_W'(16)) begin
            pins_o.clk = r[0];
            pins_o.dio = byte_val[r[3:1]];
        end else begin
            // Acknowledge slot: data held low, clock low then high.
            pins_o.clk = r[0];
            pins_o.dio = 1'b0;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/fdsd_out_skid.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdsd_out_skid
// Result register with a skid slot so the input side keeps flowing.
// ----------------------------------------------------------------------------
module fdsd_out_skid
    import fdsd_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid_i,
    output logic               in_ready_o,
    input  wire fdsd_result_t  in_data_i,
    output logic               out_valid_o,
    input  wire logic          out_ready_i,
    output fdsd_result_t       out_data_o
);

    logic         out_valid_reg;
    logic         out_valid_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;
    fdsd_result_t out_reg;
    fdsd_result_t out_next;
    fdsd_result_t skid_reg;
    fdsd_result_t skid_next;
    logic         take;

    assign in_ready_o = !skid_valid_reg;
    assign take       = in_valid_i && !skid_valid_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || out_ready_i) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = in_data_i;
                out_valid_next = take;
            end
        end else if (take) begin
            skid_next       = in_data_i;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid_o = out_valid_reg;
    assign out_data_o  = out_reg;

endmodule
`default_nettype wire

@@ hw/rtl/four_digit_seven_segment_serial_driver_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// four_digit_seven_segment_serial_driver_core
// Two-wire display writer: a load arms a three-frame sequence, each tick
// transfer advances it by one phase and reports the pin levels.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tuser: operation (0 tick, 1 load); tdata: value
//  m_axis    out        tdata: clk_level, dio_level, busy_res
//  cfg       in         brightness write, no read-back
//
// One transfer is taken per clock cycle while the skid slot is empty; each yields one result transfer,
// set by the phase counter and pin registers updated in the cycle of the
// transfer. The result waits in an output register with one skid slot.
// Digits are split one per cycle after a load, well before any is sent.
// Reset is synchronous, active low, and leaves both pins high and idle.
// ----------------------------------------------------------------------------
module four_digit_seven_segment_serial_driver_core
    import fdsd_pkg::*;
#(
    parameter int DIGITS = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] value
    input  wire logic [0:0]  s_axis_tuser,   // [0] operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [7:0]  m_axis_tdata,   // [0] clk_level, [1] dio_level, [2] busy_res
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_wr_data
);

    localparam int MID_FRAME    = 2 * START_LEN + BYTE_SLOT * (1 + DIGITS);
    localparam int TOTAL_PHASES = 2 * SHORT_FRAME + MID_FRAME;

    logic [PHASE_W-1:0]     phase_reg;
    logic [PHASE_W-1:0]     phase_next;
    logic                   clk_reg;
    logic                   clk_next;
    logic                   dio_reg;
    logic                   dio_next;
    logic [2:0]             brightness_reg;
    logic                   accept;
    logic                   idle;
    logic                   load_start;
    logic                   tick;
    logic [DIGITS-1:0][3:0] digits;
    fdsd_pins_t             pins;
    fdsd_result_t           result;
    fdsd_result_t           out_data;

    assign accept     = s_axis_tvalid && s_axis_tready;
    assign idle       = (phase_reg == '0);
    assign load_start = accept && s_axis_tuser[0] && idle;
    assign tick       = accept && !s_axis_tuser[0] && !idle;

    fdsd_digit_split #(
        .DIGITS (DIGITS)
    ) u_split (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start_i  (load_start),
        .value_i  (s_axis_tdata),
        .digits_o (digits)
    );

    fdsd_phase_gen #(
        .DIGITS (DIGITS)
    ) u_phase (
        .phase_i      (phase_reg),
        .digits_i     (digits),
        .brightness_i (brightness_reg),
        .pins_o       (pins)
    );

    always_comb begin
        phase_next = phase_reg;
        clk_next   = clk_reg;
        dio_next   = dio_reg;
        if (load_start) begin
            phase_next = PHASE_W'(1);
        end else if (tick) begin
            clk_next = pins.clk;
            dio_next = pins.dio;
            if (phase_reg >= PHASE_W'(TOTAL_PHASES)) begin
                phase_next = '0;
            end else begin
                phase_next = PHASE_W'(phase_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= '0;
            clk_reg        <= 1'b1;
            dio_reg        <= 1'b1;
            brightness_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            clk_reg   <= clk_next;
            dio_reg   <= dio_next;
            if (cfg_wr_en) begin
                brightness_reg <= cfg_wr_data;
            end
        end
    end

    assign result.clk  = clk_next;
    assign result.dio  = dio_next;
    assign result.busy = (phase_next != '0);

    fdsd_out_skid u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid_i  (s_axis_tvalid),
        .in_ready_o  (s_axis_tready),
        .in_data_i   (result),
        .out_valid_o (m_axis_tvalid),
        .out_ready_i (m_axis_tready),
        .out_data_o  (out_data)
    );

    assign m_axis_tdata = {5'b0, out_data.busy, out_data.dio, out_data.clk};

endmodule
`default_nettype wire
